FILE: rtl/scrc_pkg.sv
// Shared types and constants for the serial command relay controller.
// Holds the command texts, line-end codes and the match code enum.
// No dependencies.
package scrc_pkg;

  // Line-end characters
  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_LF = 8'h0a;

  // Matcher position that marks a dead matcher
  localparam logic [3:0] POS_DEAD = 4'hf;

  // Matcher indexes
  localparam logic [1:0] IDX_VER  = 2'd0;
  localparam logic [1:0] IDX_ON   = 2'd1;
  localparam logic [1:0] IDX_OFF  = 2'd2;
  localparam logic [1:0] IDX_STAT = 2'd3;

  // Match code reported with each result
  typedef enum logic [2:0] {
    CMD_NONE = 3'd0,
    CMD_VER  = 3'd1,
    CMD_ON   = 3'd2,
    CMD_OFF  = 3'd3,
    CMD_STAT = 3'd4
  } cmd_code_e;

  // Command text, right-aligned, first character in the highest used byte
  function automatic logic [63:0] cmd_text(logic [1:0] which);
    logic [63:0] txt;
    case (which)
      IDX_VER:  txt = 64'("ver");
      IDX_ON:   txt = 64'("ac on");
      IDX_OFF:  txt = 64'("ac off");
      IDX_STAT: txt = 64'("ac stat");
      default:  txt = '0;
    endcase
    return txt;
  endfunction

  // Command length in characters, line end not counted
  function automatic logic [3:0] cmd_len(logic [1:0] which);
    logic [3:0] len;
    case (which)
      IDX_VER:  len = 4'd3;
      IDX_ON:   len = 4'd5;
      IDX_OFF:  len = 4'd6;
      IDX_STAT: len = 4'd7;
      default:  len = 4'd0;
    endcase
    return len;
  endfunction

  // Character at position p of a command; valid for p below the length
  function automatic logic [7:0] cmd_char(logic [1:0] which, logic [2:0] p);
    logic [63:0] txt;
    logic [2:0]  sel;
    txt = cmd_text(which);
    sel = 3'(cmd_len(which) - 4'd1 - {1'b0, p});
    return txt[{sel, 3'b000} +: 8];
  endfunction

endpackage

FILE: rtl/scrc_matcher.sv
// One command matcher: tracks the position in a fixed command text.
// Depends on scrc_pkg for the command texts and lengths.
module scrc_matcher
  import scrc_pkg::*;
#(
  parameter logic [1:0] Which = 2'd0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       eol_i,
  output logic       hit_o
);

  localparam logic [3:0] Len = cmd_len(Which);

  logic [3:0] pos_q, pos_d;
  logic       hit;

  // Advance on a matching character, die on anything else
  always_comb begin
    hit   = 1'b0;
    pos_d = pos_q;
    if (step_i) begin
      if (pos_q > Len) begin
        pos_d = POS_DEAD;
      end else if (pos_q == Len) begin
        pos_d = POS_DEAD;
        hit   = eol_i;
      end else if (cmd_char(Which, pos_q[2:0]) != byte_i) begin
        pos_d = POS_DEAD;
      end else begin
        pos_d = pos_q + 4'd1;
      end
      // A line end restarts every matcher
      if (eol_i) begin
        pos_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  assign hit_o = hit;

endmodule

FILE: rtl/serial_command_relay_controller.sv
// Top level of the serial command relay controller.
// Depends on scrc_pkg and scrc_matcher.
//
// Takes one request per cycle, a received serial byte or a sample of the two
// active-low override switches, and returns one result per request through
// the input register and then the result register. The matchers, command
// state and switch latches all update as a request moves between those
// registers, so requests may follow back to back; the block stalls its input
// only while a full result register is stalled.
// The relay drive gives forced off priority over forced on, and forced on
// priority over the last "ac on" / "ac off" command.
module serial_command_relay_controller
  import scrc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       func_i,
  input  logic [7:0] rx_byte_i,
  input  logic       force_off_level_i,
  input  logic       force_on_level_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       echo_valid_o,
  output logic [7:0] echo_byte_o,
  output logic       line_end_o,
  output logic [2:0] matched_command_o,
  output logic       relay_on_o,
  output logic       cmd_on_state_o,
  output logic       force_off_active_o,
  output logic       force_on_active_o
);

  // Input register
  logic       in_vld_q;
  logic       func_q;
  logic [7:0] byte_q;
  logic       off_lvl_q, on_lvl_q;

  // Block state
  logic       cmd_on_q, cmd_on_d;
  logic       frc_off_q, frc_off_d;
  logic       frc_on_q, frc_on_d;

  // Result register
  logic       out_vld_q;
  logic       echo_vld_q;
  logic [7:0] echo_byte_q;
  logic       line_end_q;
  cmd_code_e  match_q;
  logic       relay_q;
  logic       cmd_on_out_q;
  logic       frc_off_out_q, frc_on_out_q;

  logic       advance, accept, step, eol, relay;
  logic [3:0] hits;
  cmd_code_e  match;

  // Pipeline control: move on when the result register is free or being taken
  assign advance    = !out_vld_q || !out_stall_i;
  assign in_stall_o = in_vld_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign step       = in_vld_q && advance && !func_q;
  assign eol        = (byte_q == CHAR_CR) || (byte_q == CHAR_LF);

  // Capture the request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (advance || !in_vld_q) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q    <= func_i;
      byte_q    <= rx_byte_i;
      off_lvl_q <= force_off_level_i;
      on_lvl_q  <= force_on_level_i;
    end
  end

  // Command matchers
  scrc_matcher #(.Which(IDX_VER)) u_match_ver (
    .clk_i (clk_i), .rst_ni(rst_ni), .step_i(step), .byte_i(byte_q),
    .eol_i (eol),   .hit_o (hits[0])
  );
  scrc_matcher #(.Which(IDX_ON)) u_match_on (
    .clk_i (clk_i), .rst_ni(rst_ni), .step_i(step), .byte_i(byte_q),
    .eol_i (eol),   .hit_o (hits[1])
  );
  scrc_matcher #(.Which(IDX_OFF)) u_match_off (
    .clk_i (clk_i), .rst_ni(rst_ni), .step_i(step), .byte_i(byte_q),
    .eol_i (eol),   .hit_o (hits[2])
  );
  scrc_matcher #(.Which(IDX_STAT)) u_match_stat (
    .clk_i (clk_i), .rst_ni(rst_ni), .step_i(step), .byte_i(byte_q),
    .eol_i (eol),   .hit_o (hits[3])
  );

  // Encode the completed command
  always_comb begin
    if (hits[3]) begin
      match = CMD_STAT;
    end else if (hits[2]) begin
      match = CMD_OFF;
    end else if (hits[1]) begin
      match = CMD_ON;
    end else if (hits[0]) begin
      match = CMD_VER;
    end else begin
      match = CMD_NONE;
    end
  end

  // Update command state and switch latches, then apply override priority
  always_comb begin
    cmd_on_d  = cmd_on_q;
    frc_off_d = frc_off_q;
    frc_on_d  = frc_on_q;
    if (in_vld_q && advance) begin
      if (func_q) begin
        frc_off_d = !off_lvl_q;
        frc_on_d  = !on_lvl_q;
      end else if (hits[2]) begin
        cmd_on_d = 1'b0;
      end else if (hits[1]) begin
        cmd_on_d = 1'b1;
      end
    end
    if (frc_off_d) begin
      relay = 1'b0;
    end else if (frc_on_d) begin
      relay = 1'b1;
    end else begin
      relay = cmd_on_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_on_q  <= 1'b0;
      frc_off_q <= 1'b0;
      frc_on_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      cmd_on_q  <= cmd_on_d;
      frc_off_q <= frc_off_d;
      frc_on_q  <= frc_on_d;
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (in_vld_q && advance) begin
      echo_vld_q    <= !func_q;
      echo_byte_q   <= func_q ? 8'h00 : byte_q;
      line_end_q    <= !func_q && eol;
      match_q       <= match;
      relay_q       <= relay;
      cmd_on_out_q  <= cmd_on_d;
      frc_off_out_q <= frc_off_d;
      frc_on_out_q  <= frc_on_d;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign echo_valid_o       = echo_vld_q;
  assign echo_byte_o        = echo_byte_q;
  assign line_end_o         = line_end_q;
  assign matched_command_o  = match_q;
  assign relay_on_o         = relay_q;
  assign cmd_on_state_o     = cmd_on_out_q;
  assign force_off_active_o = frc_off_out_q;
  assign force_on_active_o  = frc_on_out_q;

`ifndef SYNTHESIS
  // A completed command is only reported on a line end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && match_q != CMD_NONE) |-> (echo_valid_o && line_end_o))
    else $error("match reported without a line end");

  // Forced off always keeps the relay open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && force_off_active_o) |-> !relay_on_o)
    else $error("relay driven while forced off");

  // No byte completes two commands
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hits))
    else $error("several matchers completed at once");

  // A stalled input request only waits behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled with result register free");
`endif

endmodule
